/* design/xtea_pkg.sv */
// Shared types, constants and per-stage round constants for the XTEA cipher.
// No dependencies; every other design file uses this package.
package xtea_pkg;

	localparam int WordW        = 32;
	localparam int KeyWords     = 4;
	localparam int KeyIdxW      = 2;
	localparam int RoundCycles  = 64;
	localparam int HalfRounds   = 2 * RoundCycles;
	localparam int KeySelShift  = 11;
	localparam logic [WordW-1:0] Delta = 32'h9E37_79B9;

	// direction codes
	localparam logic ActEncrypt = 1'b0;
	localparam logic ActDecrypt = 1'b1;

	typedef logic [WordW-1:0] word_t;
	typedef logic [KeyWords-1:0][WordW-1:0] key_arr_t;
	typedef logic [KeyIdxW-1:0] key_idx_t;

	// data carried through the round pipeline
	typedef struct packed {
		logic  act;
		word_t v0;
		word_t v1;
	} xtea_blk_t;

	// result word
	typedef struct packed {
		word_t first;
		word_t second;
	} xtea_res_t;

	// Round sum seen by half-round h (0 .. HalfRounds-1), worked out at elaboration.
	function automatic word_t half_sum(input int h, input logic dec);
		int          n;
		logic [63:0] p;
		n = h / 2;
		if (dec == ActEncrypt) begin
			p = 64'(((h % 2) == 0) ? n : n + 1) * 64'(Delta);
		end else begin
			p = 64'(((h % 2) == 0) ? RoundCycles - n : RoundCycles - n - 1) * 64'(Delta);
		end
		return p[WordW-1:0];
	endfunction

endpackage

/* design/xtea_in_if.sv */
// Input channel: one block and its direction per word.
// Depends on xtea_pkg for the word type.
interface xtea_in_if;
	logic              valid;
	logic              ready;
	logic              action;
	xtea_pkg::word_t   word_first;
	xtea_pkg::word_t   word_second;

	modport source (output valid, action, word_first, word_second, input ready);
	modport sink   (input valid, action, word_first, word_second, output ready);
endinterface

/* design/xtea_out_if.sv */
// Output channel: the two result halves per word.
// Depends on xtea_pkg for the word type.
interface xtea_out_if;
	logic              valid;
	logic              ready;
	xtea_pkg::word_t   out_first;
	xtea_pkg::word_t   out_second;

	modport source (output valid, out_first, out_second, input ready);
	modport sink   (input valid, out_first, out_second, output ready);
endinterface

/* design/xtea_block_cipher.sv */
// XTEA cipher, 128 Feistel half-rounds (RoundCycles = 64), fully pipelined top level.
// Depends on xtea_pkg, xtea_in_if, xtea_out_if, xtea_round and xtea_skid.
//
// Usage:
//  - Load the 128-bit key through cfg_we/cfg_index/cfg_data (index 0..3,
//    one 32-bit key word each) while no block is in flight.
//  - blk_in carries one word per accepted handshake: action (0 encrypt,
//    1 decrypt), word_first and word_second.
//  - blk_out returns out_first/out_second, one word per input word, in order.
//  - Each accepted word passes through one register stage per half-round
//    and then the output register; the first stage loads at the accepting
//    edge itself.
//  - Throughput: one word per cycle unless the receiver stalls; every half-round has its own stage.
//  - When the receiver stalls, one more result parks in the skid register;
//    after that blk_in.ready drops and the whole pipeline holds in place
//    until the output word is taken.
//  - Reset clears the key to zero and drops all valid bits; in-flight
//    words are discarded.
module xtea_block_cipher (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  xtea_pkg::key_idx_t   cfg_index,
	input  xtea_pkg::word_t      cfg_data,
	xtea_in_if.sink              blk_in,
	xtea_out_if.source           blk_out
);
	import xtea_pkg::*;

	key_arr_t  key_q;
	logic      en;
	logic      vld [HalfRounds+1];
	xtea_blk_t blk [HalfRounds+1];
	xtea_res_t res;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	// pipeline entry
	assign blk_in.ready   = en;
	assign vld[0]         = blk_in.valid;
	assign blk[0].act     = blk_in.action;
	assign blk[0].v0      = blk_in.word_first;
	assign blk[0].v1      = blk_in.word_second;

	// one stage per half-round
	for (genvar h = 0; h < HalfRounds; h++) begin : g_round
		xtea_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.half_odd (1'((h % 2) == 1)),
			.enc_sum  (half_sum(h, ActEncrypt)),
			.dec_sum  (half_sum(h, ActDecrypt)),
			.key      (key_q),
			.vld_in   (vld[h]),
			.blk_in   (blk[h]),
			.vld_s1   (vld[h+1]),
			.blk_s1   (blk[h+1])
		);
	end

	// output register and skid
	assign res.first  = blk[HalfRounds].v0;
	assign res.second = blk[HalfRounds].v1;

	xtea_skid u_skid (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (vld[HalfRounds] & en),
		.res_in (res),
		.en     (en),
		.out_ch (blk_out)
	);

	// an accepted word shows up in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(blk_in.valid && blk_in.ready) |=> vld[1])
		else $error("accepted word missing from first stage");

	// a stalled pipeline keeps its last stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld[HalfRounds]))
		else $error("last stage changed during stall");

	// skid only fills behind a held output word
	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> blk_out.valid)
		else $error("skid full with empty output register");

endmodule

/* design/xtea_round.sv */
// One Feistel half-round of XTEA followed by its pipeline register.
// Depends on xtea_pkg; stage constants arrive as tied-off ports.
module xtea_round (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                half_odd,
	input  xtea_pkg::word_t     enc_sum,
	input  xtea_pkg::word_t     dec_sum,
	input  xtea_pkg::key_arr_t  key,
	input  logic                vld_in,
	input  xtea_pkg::xtea_blk_t blk_in,
	output logic                vld_s1,
	output xtea_pkg::xtea_blk_t blk_s1
);
	import xtea_pkg::*;

	logic     upd_v0;
	word_t    sum;
	key_idx_t sel;
	word_t    src;
	word_t    dst;
	word_t    mixed;
	word_t    f;
	word_t    res;
	xtea_blk_t blk_nxt;

	// which half moves and which key word is used follow from parity and direction
	always_comb begin
		upd_v0  = (half_odd == blk_in.act);
		sum     = (blk_in.act == ActDecrypt) ? dec_sum : enc_sum;
		sel     = upd_v0 ? sum[KeyIdxW-1:0] : sum[KeySelShift +: KeyIdxW];
		src     = upd_v0 ? blk_in.v1 : blk_in.v0;
		dst     = upd_v0 ? blk_in.v0 : blk_in.v1;
		mixed   = ((src << 4) ^ (src >> 5)) + src;
		f       = mixed ^ (sum + key[sel]);
		res     = (blk_in.act == ActDecrypt) ? dst - f : dst + f;
		blk_nxt = blk_in;
		if (upd_v0) begin
			blk_nxt.v0 = res;
		end else begin
			blk_nxt.v1 = res;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			blk_s1 <= blk_nxt;
		end
	end

endmodule

/* design/xtea_skid.sv */
// Output register with a one-word skid stage behind the round pipeline.
// Depends on xtea_pkg and xtea_out_if.
module xtea_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_in,
	input  xtea_pkg::xtea_res_t res_in,
	output logic                en,
	xtea_out_if.source          out_ch
);
	import xtea_pkg::*;

	logic      out_v_q;
	logic      skid_v_q;
	xtea_res_t out_q;
	xtea_res_t skid_q;
	logic      take;
	logic      to_out;

	assign take   = out_v_q & out_ch.ready;
	assign en     = ~skid_v_q;
	assign to_out = ~out_v_q | take;

	// occupancy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (vld_in) begin
			if (to_out) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	// payload moves
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (vld_in) begin
			if (to_out) begin
				out_q <= res_in;
			end else begin
				skid_q <= res_in;
			end
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.out_first  = out_q.first;
	assign out_ch.out_second = out_q.second;

endmodule

/* bench/testbench.sv */
// Self-checking bench for xtea_block_cipher: drives blocks over blk_in, checks blk_out.
// Depends on xtea_pkg, xtea_in_if, xtea_out_if and the xtea_block_cipher design files.
module testbench;
	import xtea_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	key_idx_t cfg_index;
	word_t cfg_data;

	xtea_in_if blk_in_ch ();
	xtea_out_if blk_out_ch ();

	xtea_block_cipher u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.blk_in    (blk_in_ch),
		.blk_out   (blk_out_ch)
	);

	// key as the design should hold it, and results still owed by the pipeline
	key_arr_t key_model;
	xtea_res_t pending_results[$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int mismatch_count;
	int blocks_sent;
	int results_checked;
	int encrypt_count;
	int decrypt_count;
	int key_loads;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one XTEA mixing term: ((v << 4) ^ (v >> 5)) + v
	function automatic word_t feistel_mix(input word_t v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

	// expected output word for one block under the current key
	function automatic xtea_res_t cipher_block(input logic act, input word_t first,
		input word_t second);
		word_t v0;
		word_t v1;
		word_t sum;
		xtea_res_t res;
		int n;
		v0 = first;
		v1 = second;
		if (act == ActEncrypt) begin
			sum = '0;
			for (n = 0; n < RoundCycles; n++) begin
				v0 = v0 + (feistel_mix(v1) ^ (sum + key_model[key_idx_t'(sum)]));
				sum = sum + Delta;
				v1 = v1 + (feistel_mix(v0) ^
					(sum + key_model[key_idx_t'(sum >> KeySelShift)]));
			end
		end else begin
			// decryption starts from delta times the cycle count, wrapped
			sum = Delta * word_t'(RoundCycles);
			for (n = 0; n < RoundCycles; n++) begin
				v1 = v1 - (feistel_mix(v0) ^
					(sum + key_model[key_idx_t'(sum >> KeySelShift)]));
				sum = sum - Delta;
				v0 = v0 - (feistel_mix(v1) ^ (sum + key_model[key_idx_t'(sum)]));
			end
		end
		res.first = v0;
		res.second = v1;
		return res;
	endfunction

	// random data word, biased toward the edges
	function automatic word_t random_word();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return word_t'(1) << $urandom_range(WordW - 1);
			3: return ~(word_t'(1) << $urandom_range(WordW - 1));
			default: return $urandom();
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 20)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// send one block; returns at the edge where it is accepted
	task automatic send_block(input logic act, input word_t first, input word_t second);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			blk_in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		blk_in_ch.valid <= 1'b1;
		blk_in_ch.action <= act;
		blk_in_ch.word_first <= first;
		blk_in_ch.word_second <= second;
		@(posedge clk);
		while (!blk_in_ch.ready)
			@(posedge clk);
		pending_results.push_back(cipher_block(act, first, second));
		blocks_sent++;
		if (act == ActEncrypt)
			encrypt_count++;
		else
			decrypt_count++;
	endtask

	// stop sending and wait until every owed word has come back
	task automatic drain_results();
		blk_in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// write all four key words; only called with the pipeline empty
	task automatic load_key(input key_arr_t kw);
		int i;
		for (i = 0; i < KeyWords; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= key_idx_t'(i);
			cfg_data <= kw[i];
			key_model[i] = kw[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		key_loads++;
	endtask

	// encrypt a block, then decrypt the expected ciphertext
	task automatic send_round_trip(input word_t first, input word_t second);
		xtea_res_t ct;
		ct = cipher_block(ActEncrypt, first, second);
		send_block(ActEncrypt, first, second);
		send_block(ActDecrypt, ct.first, ct.second);
	endtask

	// output side: random stall, long hold-off on request, compare each word
	initial begin
		xtea_res_t want;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (blk_out_ch.valid && blk_out_ch.ready) begin
					if (pending_results.size() == 0) begin
						report_mismatch($sformatf("output word %h_%h with no block pending",
							blk_out_ch.out_first, blk_out_ch.out_second));
					end else begin
						want = pending_results.pop_front();
						if (blk_out_ch.out_first !== want.first)
							report_mismatch($sformatf("out_first %h, expected %h",
								blk_out_ch.out_first, want.first));
						if (blk_out_ch.out_second !== want.second)
							report_mismatch($sformatf("out_second %h, expected %h",
								blk_out_ch.out_second, want.second));
						results_checked++;
					end
				end
				if (hold_cycles > 0) begin
					hold_cycles--;
					blk_out_ch.ready <= 1'b0;
				end else begin
					blk_out_ch.ready <= (recv_stall_pct == 0) ||
						($urandom_range(99) >= recv_stall_pct);
				end
			end
		end
	end

	// corner keys and blocks, every direction, round trips
	task automatic test_corner_blocks();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// reset key is all zeros
		send_block(ActEncrypt, '0, '0);
		send_block(ActDecrypt, '0, '0);
		send_block(ActEncrypt, '1, '1);
		send_block(ActDecrypt, '1, '1);
		send_block(ActEncrypt, 32'hAAAA_AAAA, 32'h5555_5555);
		send_block(ActDecrypt, 32'h5555_5555, 32'hAAAA_AAAA);
		send_block(ActEncrypt, 32'h0000_0001, 32'h8000_0000);
		drain_results();
		load_key({KeyWords{32'hFFFF_FFFF}});
		send_block(ActEncrypt, '0, '0);
		send_block(ActDecrypt, '0, '0);
		send_block(ActEncrypt, '1, '1);
		send_round_trip(32'h8000_0000, 32'h0000_0001);
		drain_results();
		// distinct words so a wrong key select shows up
		load_key({32'h7FFF_FFFF, 32'hDEAD_BEEF, 32'h8000_0000, 32'h0000_0001});
		send_round_trip(32'h0123_4567, 32'h89AB_CDEF);
		send_block(ActEncrypt, '0, '1);
		send_block(ActDecrypt, '1, '0);
		send_round_trip(32'hFFFF_FFFE, 32'h7FFF_FFFF);
		drain_results();
	endtask

	// receiver holds off long enough for the pipeline to fill and stall the input
	task automatic test_backpressure();
		int i;
		load_key({$urandom(), $urandom(), $urandom(), $urandom()});
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 400;
		for (i = 0; i < 200; i++)
			send_block(1'($urandom_range(1)), random_word(), random_word());
		drain_results();
	endtask

	// random blocks under two random keys with the given idle rates
	task automatic test_random_traffic(input int send_pct, input int stall_pct,
		input int n_blocks);
		int k;
		int i;
		key_arr_t kw;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		for (k = 0; k < 2; k++) begin
			drain_results();
			for (i = 0; i < KeyWords; i++)
				kw[i] = random_word();
			load_key(kw);
			i = 0;
			while (i < n_blocks) begin
				if ($urandom_range(4) == 0) begin
					send_round_trip(random_word(), random_word());
					i += 2;
				end else begin
					send_block(1'($urandom_range(1)), random_word(), random_word());
					i++;
				end
			end
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		blk_in_ch.valid = 1'b0;
		blk_in_ch.action = ActEncrypt;
		blk_in_ch.word_first = '0;
		blk_in_ch.word_second = '0;
		blk_out_ch.ready = 1'b0;
		key_model = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		mismatch_count = 0;
		blocks_sent = 0;
		results_checked = 0;
		encrypt_count = 0;
		decrypt_count = 0;
		key_loads = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_blocks();
		test_backpressure();
		test_random_traffic(0, 0, 170);
		test_random_traffic(85, 0, 170);
		test_random_traffic(0, 85, 170);
		test_random_traffic(16, 16, 170);

		// nothing owed; watch for stray output words past the pipeline depth
		drain_results();
		repeat (2 * HalfRounds + 2) @(posedge clk);
		$display("Covered %0d blocks (%0d encrypt, %0d decrypt) under %0d key loads,",
			blocks_sent, encrypt_count, decrypt_count, key_loads);
		$display("with full-pipeline stall and idle/stall mixes; %0d words checked, %0d bad.",
			results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
